[hdl/mns_pkg.sv]
// mns_pkg: shared types and codes for the Markov note sampler.
// Holds command, status and register codes, the controller state type and
// the control/status structs between mns_ctrl and mns_datapath. No dependencies.
package mns_pkg;

	// Item commands
	localparam logic [1:0] CMD_WRITE   = 2'd0;
	localparam logic [1:0] CMD_DRAW    = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;
	localparam logic [1:0] CMD_NOP     = 2'd3;

	// Result status codes
	localparam logic [1:0] STAT_FULL      = 2'd0;
	localparam logic [1:0] STAT_NOTE_ONLY = 2'd1;
	localparam logic [1:0] STAT_NONE      = 2'd2;

	// Configuration register indexes
	localparam logic REG_MIN_TONE   = 1'b0;
	localparam logic REG_NOTE_COUNT = 1'b1;

	// Field widths
	localparam int MIN_TONE_W   = 7;
	localparam int NOTE_COUNT_W = 6;
	localparam int CFG_DATA_W   = 7;
	localparam int WEIGHT_W     = 16;
	localparam logic [NOTE_COUNT_W-1:0] NOTE_COUNT_RST = 6'd32;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_NOTE,
		ST_LEN,
		ST_DONE
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic wr_en;      // store one weight from the item fields
		logic restart;    // current note back to index zero
		logic draw_init;  // latch draws, start the note walk
		logic walk;       // walk running: issue reads, accumulate
		logic len_mode;   // walk is over length bins
		logic note_take;  // note found: take it, start the length walk
		logic note_miss;  // no note found: finish with status none
		logic len_take;   // length found: finish with full status
		logic len_miss;   // no length found: finish with note only
	} ctl_t;

	// Status from datapath to controller
	typedef struct packed {
		logic hit;   // checked running sum exceeds the draw
		logic miss;  // walk exhausted without a hit
	} stat_t;

endpackage

[hdl/mns_ctrl.sv]
// mns_ctrl: controller state machine of the Markov note sampler.
// Decodes items, sequences the note and length walks, raises the result strobe.
// Depends on mns_pkg.
module mns_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [1:0]      cmd,
	input  mns_pkg::stat_t  st,
	output mns_pkg::ctl_t   ctl,
	output logic            busy,
	output logic            done
);

	mns_pkg::state_t state_q, state_nx;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mns_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and commands
	always_comb begin
		state_nx = state_q;
		ctl      = '0;
		unique case (state_q)
			mns_pkg::ST_IDLE: begin
				if (start) begin
					unique case (cmd)
						mns_pkg::CMD_WRITE: ctl.wr_en = 1'b1;
						mns_pkg::CMD_RESTART: ctl.restart = 1'b1;
						mns_pkg::CMD_DRAW: begin
							ctl.draw_init = 1'b1;
							state_nx      = mns_pkg::ST_NOTE;
						end
						default: ;
					endcase
				end
			end
			mns_pkg::ST_NOTE: begin
				ctl.walk = 1'b1;
				priority if (st.hit) begin
					ctl.note_take = 1'b1;
					state_nx      = mns_pkg::ST_LEN;
				end else if (st.miss) begin
					ctl.note_miss = 1'b1;
					state_nx      = mns_pkg::ST_DONE;
				end else begin
					// keep walking the note columns
				end
			end
			mns_pkg::ST_LEN: begin
				ctl.walk     = 1'b1;
				ctl.len_mode = 1'b1;
				priority if (st.hit) begin
					ctl.len_take = 1'b1;
					state_nx     = mns_pkg::ST_DONE;
				end else if (st.miss) begin
					ctl.len_miss = 1'b1;
					state_nx     = mns_pkg::ST_DONE;
				end else begin
					// keep walking the length bins
				end
			end
			mns_pkg::ST_DONE: state_nx = mns_pkg::ST_IDLE;
			default: state_nx = mns_pkg::ST_IDLE;
		endcase
	end

	assign busy = (state_q != mns_pkg::ST_IDLE);
	assign done = (state_q == mns_pkg::ST_DONE);

endmodule

[hdl/mns_datapath.sv]
// mns_datapath: weight table, configuration registers, walk counter and
// running sum, current note and result registers of the Markov note sampler.
// Depends on mns_pkg; driven by mns_ctrl.
module mns_datapath #(
	parameter int MAX_NOTES = 32,
	parameter int BINS      = 9
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mns_pkg::ctl_t                   ctl,
	output mns_pkg::stat_t                  st,
	input  logic                            cfg_we,
	input  logic                            cfg_idx,
	input  logic [mns_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [4:0]                      row_index,
	input  logic [4:0]                      column_index,
	input  logic [3:0]                      bin_index,
	input  logic [mns_pkg::WEIGHT_W-1:0]    weight,
	input  logic [mns_pkg::WEIGHT_W-1:0]    note_draw,
	input  logic [mns_pkg::WEIGHT_W-1:0]    length_draw,
	output logic [7:0]                      note,
	output logic [3:0]                      length_code,
	output logic [1:0]                      status
);

	localparam int DEPTH = MAX_NOTES * MAX_NOTES * BINS;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = $clog2(MAX_NOTES);
	localparam int LW    = $clog2(MAX_NOTES + 1);
	localparam int WMAX  = (MAX_NOTES > BINS) ? MAX_NOTES : BINS;
	localparam int CW    = $clog2(WMAX + 1);
	localparam int SW    = mns_pkg::WEIGHT_W + $clog2(WMAX);
	localparam int WW    = mns_pkg::WEIGHT_W;

	// Weight table and registered read port
	logic [WW-1:0] mem [DEPTH];
	logic [WW-1:0] rdata_q;

	logic [mns_pkg::MIN_TONE_W-1:0]   min_tone_q;
	logic [mns_pkg::NOTE_COUNT_W-1:0] note_count_q;
	logic [IW-1:0] cur_idx_q;
	logic [IW-1:0] old_row_q;
	logic [IW-1:0] note_idx_q;
	logic [LW-1:0] limit_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] chk_q;
	logic          pend_q;
	logic [SW-1:0] sum_q;
	logic [WW-1:0] nd_q;
	logic [WW-1:0] ld_q;
	logic [7:0]    note_q;
	logic [3:0]    code_q;
	logic [1:0]    stat_q;

	logic [AW-1:0] wr_addr;
	logic          wr_ok;
	logic [AW-1:0] rd_addr;
	logic          more;
	logic [SW-1:0] sum_nx;
	logic [WW-1:0] thr;

	// Write address and range check
	always_comb begin
		wr_ok   = (32'(row_index) < MAX_NOTES) && (32'(column_index) < MAX_NOTES)
			&& (32'(bin_index) < BINS);
		wr_addr = AW'((32'(row_index) * MAX_NOTES + 32'(column_index)) * BINS
			+ 32'(bin_index));
	end

	// Read address of the walk: note column or length bin of the chosen entry
	always_comb begin
		if (ctl.len_mode) begin
			rd_addr = AW'((32'(old_row_q) * MAX_NOTES + 32'(note_idx_q)) * BINS
				+ 32'(cnt_q));
			more    = (32'(cnt_q) < BINS);
		end else begin
			rd_addr = AW'((32'(old_row_q) * MAX_NOTES + 32'(cnt_q)) * BINS);
			more    = (32'(cnt_q) < 32'(limit_q));
		end
	end

	// Running sum check against the draw
	always_comb begin
		thr     = ctl.len_mode ? ld_q : nd_q;
		sum_nx  = sum_q + SW'(rdata_q);
		st.hit  = pend_q && (sum_nx > SW'(thr));
		st.miss = !more && !st.hit;
	end

	// Table memory
	always_ff @(posedge clk) begin
		if (ctl.wr_en && wr_ok) begin
			mem[wr_addr] <= weight;
		end
		rdata_q <= mem[rd_addr];
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_tone_q   <= '0;
			note_count_q <= mns_pkg::NOTE_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				mns_pkg::REG_MIN_TONE:   min_tone_q   <= cfg_data[mns_pkg::MIN_TONE_W-1:0];
				mns_pkg::REG_NOTE_COUNT: note_count_q <= cfg_data[mns_pkg::NOTE_COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Walk control and current note
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_idx_q <= '0;
			cnt_q     <= '0;
			pend_q    <= 1'b0;
		end else begin
			priority if (ctl.restart) begin
				cur_idx_q <= '0;
			end else if (ctl.draw_init) begin
				cnt_q  <= '0;
				pend_q <= 1'b0;
			end else if (ctl.note_take) begin
				cur_idx_q <= IW'(chk_q);
				cnt_q     <= CW'(1);
				pend_q    <= 1'b0;
			end else if (ctl.walk) begin
				pend_q <= more;
				if (more) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end else begin
				// idle: hold
			end
		end
	end

	// Walk payload: draws, row, limit, running sum, checked index, chosen note
	always_ff @(posedge clk) begin
		priority if (ctl.draw_init) begin
			nd_q      <= note_draw;
			ld_q      <= length_draw;
			old_row_q <= cur_idx_q;
			sum_q     <= '0;
			limit_q   <= LW'((32'(note_count_q) > MAX_NOTES) ? MAX_NOTES
				: 32'(note_count_q));
		end else if (ctl.note_take) begin
			note_idx_q <= IW'(chk_q);
			sum_q      <= '0;
		end else if (ctl.walk) begin
			if (pend_q) begin
				sum_q <= sum_nx;
			end
			if (more) begin
				chk_q <= cnt_q;
			end
		end else begin
			// idle: hold
		end
	end

	// Result registers
	always_ff @(posedge clk) begin
		if (ctl.note_take) begin
			note_q <= 8'(min_tone_q) + 8'(IW'(chk_q));
		end
		if (ctl.note_miss) begin
			note_q <= 8'(min_tone_q) + 8'(cur_idx_q);
			code_q <= '0;
			stat_q <= mns_pkg::STAT_NONE;
		end
		if (ctl.len_take) begin
			code_q <= 4'(chk_q);
			stat_q <= mns_pkg::STAT_FULL;
		end
		if (ctl.len_miss) begin
			code_q <= '0;
			stat_q <= mns_pkg::STAT_NOTE_ONLY;
		end
	end

	assign note        = note_q;
	assign length_code = code_q;
	assign status      = stat_q;

endmodule

[hdl/markov_note_sampler_core.sv]
// Markov note sampler: a transition table of Q0.16 weights and an inverse-CDF
// walk that draws the next note and its length code. A write, restart or no-op
// item leaves busy low, and the next item may follow at once. A draw item
// raises busy while it walks the note weights of the current row, over the
// note count in use (at most MAX_NOTES), then length bins 1 to BINS - 1 of
// the chosen entry, one table read a cycle through the single registered
// read port, and ends in a result state. The result is registered on note,
// length_code and status and valid in the single cycle in which done is
// high; the receiver cannot hold it, so it must take it then. A draw that
// finds no note skips the length walk. Table entries are not cleared at
// reset: every weight a draw may walk must be written first. Configuration
// writes must go in only while busy is low; the block does not enforce it.
// Depends on mns_pkg, mns_ctrl and mns_datapath.
module markov_note_sampler_core #(
	parameter int MAX_NOTES = 32,
	parameter int BINS      = 9
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      cmd,
	input  logic [4:0]                      row_index,
	input  logic [4:0]                      column_index,
	input  logic [3:0]                      bin_index,
	input  logic [mns_pkg::WEIGHT_W-1:0]    weight,
	input  logic [mns_pkg::WEIGHT_W-1:0]    note_draw,
	input  logic [mns_pkg::WEIGHT_W-1:0]    length_draw,
	output logic                            done,
	output logic [7:0]                      note,
	output logic [3:0]                      length_code,
	output logic [1:0]                      status,
	input  logic                            cfg_we,
	input  logic                            cfg_idx,
	input  logic [mns_pkg::CFG_DATA_W-1:0]  cfg_data
);

	mns_pkg::ctl_t  ctl;
	mns_pkg::stat_t st;

	// Controller
	mns_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.st     (st),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	// Datapath
	mns_datapath #(
		.MAX_NOTES (MAX_NOTES),
		.BINS      (BINS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.st           (st),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.row_index    (row_index),
		.column_index (column_index),
		.bin_index    (bin_index),
		.weight       (weight),
		.note_draw    (note_draw),
		.length_draw  (length_draw),
		.note         (note),
		.length_code  (length_code),
		.status       (status)
	);

	// A draw item keeps the block busy in the next cycle
	a_draw_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd == mns_pkg::CMD_DRAW) |=> busy)
		else $error("draw item accepted but block not busy");

	// Items without a result leave the block free
	a_short_free: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd != mns_pkg::CMD_DRAW) |=> !busy && !done)
		else $error("non-draw item made the block busy");

	// Result strobe lasts one cycle and ends the draw
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe held or block stayed busy");

	// Result strobe only while busy, with a defined status
	a_done_stat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy && (status <= mns_pkg::STAT_NONE))
		else $error("result strobe with bad status or while idle");

endmodule
